// ===== rtl/array_list_insert_delete_find_defines.svh =====
// Assertion macros shared by the array list modules.
// Included by the controller and the datapath; depends on nothing.
`ifndef ARRAY_LIST_INSERT_DELETE_FIND_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_FIND_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ALIDF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("array list assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ALIDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("array list assertion failed");

`endif

// ===== rtl/alidf_pkg.sv =====
// Shared types and constants for the array list block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package alidf_pkg;

   // Fixed port field widths.
   localparam int OPC_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 6;
   localparam int COUNT_W  = 7;

   // Request opcodes; the fourth code is a no-operation.
   localparam logic [OPC_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_BAD_POS,
      STATUS_NOT_FOUND
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_MOVE,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       idx_init;
      logic       idx_step;
      logic       rd_en;
      logic       wr_move;
      logic       wr_value;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       set_status;
      status_type status;
      logic       set_found;
      logic       out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_find;
      logic is_insert;
      logic is_delete;
      logic list_empty;
      logic full;
      logic ins_pos_bad;
      logic ins_at_end;
      logic del_pos_bad;
      logic del_at_end;
      logic match;
      logic scan_last;
      logic ins_last;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/alidf_ctrl.sv =====
// Controller state machine for the array list block.
// Depends on alidf_pkg and drives the datapath through cmd_type commands.
`timescale 1ns / 1ps
`include "array_list_insert_delete_find_defines.svh"

module alidf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  alidf_pkg::stat_type st,
   output alidf_pkg::cmd_type  cmd
);

   alidf_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alidf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alidf_pkg::ST_IDLE: begin
            if (req_valid) state_in = alidf_pkg::ST_DECIDE;
         end
         alidf_pkg::ST_DECIDE: begin
            if (st.is_find) begin
               state_in = st.list_empty ? alidf_pkg::ST_FINISH : alidf_pkg::ST_READ;
            end else if (st.is_insert) begin
               if (st.full || st.ins_pos_bad) state_in = alidf_pkg::ST_FINISH;
               else if (st.ins_at_end) state_in = alidf_pkg::ST_WRITE;
               else state_in = alidf_pkg::ST_READ;
            end else if (st.is_delete) begin
               if (st.del_pos_bad || st.del_at_end) state_in = alidf_pkg::ST_FINISH;
               else state_in = alidf_pkg::ST_READ;
            end else begin
               state_in = alidf_pkg::ST_FINISH;
            end
         end
         alidf_pkg::ST_READ: begin
            state_in = alidf_pkg::ST_MOVE;
         end
         alidf_pkg::ST_MOVE: begin
            if (st.is_find) begin
               state_in = (st.match || st.scan_last) ? alidf_pkg::ST_FINISH
                                                     : alidf_pkg::ST_READ;
            end else if (st.is_insert) begin
               state_in = st.ins_last ? alidf_pkg::ST_WRITE : alidf_pkg::ST_READ;
            end else begin
               state_in = st.scan_last ? alidf_pkg::ST_FINISH : alidf_pkg::ST_READ;
            end
         end
         alidf_pkg::ST_WRITE: begin
            state_in = alidf_pkg::ST_FINISH;
         end
         alidf_pkg::ST_FINISH: begin
            if (st.out_free) state_in = alidf_pkg::ST_IDLE;
         end
         default: begin
            state_in = alidf_pkg::ST_IDLE;
         end
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd        = '0;
      cmd.status = alidf_pkg::STATUS_OK;
      req_stall  = (state_ff != alidf_pkg::ST_IDLE);
      case (state_ff)
         alidf_pkg::ST_IDLE: begin
            cmd.load = req_valid;
         end
         alidf_pkg::ST_DECIDE: begin
            cmd.idx_init = 1'b1;
            if (st.is_find) begin
               if (st.list_empty) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = alidf_pkg::STATUS_NOT_FOUND;
               end
            end else if (st.is_insert) begin
               if (st.full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = alidf_pkg::STATUS_FULL;
               end else if (st.ins_pos_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = alidf_pkg::STATUS_BAD_POS;
               end
            end else if (st.is_delete) begin
               if (st.del_pos_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = alidf_pkg::STATUS_BAD_POS;
               end else if (st.del_at_end) begin
                  // Removing the last entry needs no moves.
                  cmd.cnt_dec = 1'b1;
               end
            end
         end
         alidf_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         alidf_pkg::ST_MOVE: begin
            if (st.is_find) begin
               if (st.match) begin
                  cmd.set_found = 1'b1;
               end else if (st.scan_last) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = alidf_pkg::STATUS_NOT_FOUND;
               end else begin
                  cmd.idx_step = 1'b1;
               end
            end else if (st.is_insert) begin
               cmd.wr_move  = 1'b1;
               cmd.idx_step = !st.ins_last;
            end else begin
               cmd.wr_move  = 1'b1;
               cmd.cnt_dec  = st.scan_last;
               cmd.idx_step = !st.scan_last;
            end
         end
         alidf_pkg::ST_WRITE: begin
            cmd.wr_value = 1'b1;
            cmd.cnt_inc  = 1'b1;
         end
         alidf_pkg::ST_FINISH: begin
            cmd.out_load = st.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // A move step always follows its read step.
   `ALIDF_ASSERT_IMPL(a_move_after_read, clock, reset, state_ff == alidf_pkg::ST_MOVE, $past(state_ff) == alidf_pkg::ST_READ)

endmodule

// ===== rtl/alidf_dpath.sv =====
// Datapath for the array list: element memory, count, scan index and result registers.
// Depends on alidf_pkg; commanded by alidf_ctrl.
`timescale 1ns / 1ps
`include "array_list_insert_delete_find_defines.svh"

module alidf_dpath #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [alidf_pkg::OPC_W-1:0]        req_opcode,
   input  logic [alidf_pkg::VALUE_W-1:0]      req_value,
   input  logic [alidf_pkg::POS_W-1:0]        req_position,
   input  alidf_pkg::cmd_type                 cmd,
   output alidf_pkg::stat_type                st,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [alidf_pkg::STATUS_W-1:0]     rsp_status,
   output logic [alidf_pkg::FOUND_W-1:0]      rsp_found_index,
   output logic [alidf_pkg::COUNT_W-1:0]      rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = ((CNT_W > alidf_pkg::POS_W) ? CNT_W : alidf_pkg::POS_W) + 1;

   logic [alidf_pkg::OPC_W-1:0]      op_ff;
   logic [ELEM_WIDTH-1:0]            val_ff;
   logic [alidf_pkg::POS_W-1:0]      pos_ff;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [ELEM_WIDTH-1:0]            elem_mem [DEPTH];
   logic [ELEM_WIDTH-1:0]            rd_data_ff;
   alidf_pkg::status_type            res_status_ff;
   logic [IDX_W-1:0]                 res_found_ff;
   logic                             rsp_valid_ff;
   alidf_pkg::status_type            rsp_status_ff;
   logic [alidf_pkg::FOUND_W-1:0]    rsp_found_ff;
   logic [alidf_pkg::COUNT_W-1:0]    rsp_count_ff;

   logic [CMP_W-1:0]                 count_x, pos_x, idx_x;
   logic [IDX_W-1:0]                 rd_addr, wr_addr;
   logic [ELEM_WIDTH-1:0]            wr_data;
   logic                             wr_en;
   logic                             out_free;

   // Operand capture when a request is taken.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         val_ff <= ELEM_WIDTH'(req_value);
         pos_ff <= req_position;
      end
   end

   // Common-width copies for position and count compares.
   assign count_x = CMP_W'(count_ff);
   assign pos_x   = CMP_W'(pos_ff);
   assign idx_x   = CMP_W'(idx_ff);

   // Status toward the controller.
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign st.is_find     = (op_ff == alidf_pkg::OP_FIND);
   assign st.is_insert   = (op_ff == alidf_pkg::OP_INSERT);
   assign st.is_delete   = (op_ff == alidf_pkg::OP_DELETE);
   assign st.list_empty  = (count_ff == '0);
   assign st.full        = (count_x == CMP_W'(DEPTH));
   assign st.ins_pos_bad = (pos_x == '0) || (pos_x > count_x + CMP_W'(1));
   assign st.ins_at_end  = (pos_x == count_x + CMP_W'(1));
   assign st.del_pos_bad = (pos_x == '0) || (pos_x > count_x);
   assign st.del_at_end  = (pos_x == count_x);
   assign st.match       = (rd_data_ff == val_ff);
   assign st.scan_last   = (idx_x + CMP_W'(1) == count_x);
   assign st.ins_last    = (idx_x == pos_x);
   assign st.out_free    = out_free;

   // Element count: grows on insert, shrinks on delete.
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) count_in = count_ff + CNT_W'(1);
      else if (cmd.cnt_dec) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Scan index: insert walks down from the tail, find and delete walk up.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         if (op_ff == alidf_pkg::OP_INSERT) idx_in = IDX_W'(count_ff);
         else if (op_ff == alidf_pkg::OP_DELETE) idx_in = IDX_W'(pos_ff);
         else idx_in = '0;
      end else if (cmd.idx_step) begin
         if (op_ff == alidf_pkg::OP_INSERT) idx_in = idx_ff - IDX_W'(1);
         else idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Memory addressing: insert copies entry idx-1 into idx, delete copies idx into idx-1.
   assign rd_addr = (op_ff == alidf_pkg::OP_INSERT) ? idx_ff - IDX_W'(1) : idx_ff;
   assign wr_en   = cmd.wr_move || cmd.wr_value;
   always_comb begin
      if (cmd.wr_value) begin
         wr_addr = IDX_W'(pos_x - CMP_W'(1));
         wr_data = val_ff;
      end else begin
         wr_addr = (op_ff == alidf_pkg::OP_INSERT) ? idx_ff : idx_ff - IDX_W'(1);
         wr_data = rd_data_ff;
      end
   end

   // Element memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) elem_mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= elem_mem[rd_addr];
   end

   // Result of the request in progress.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= alidf_pkg::STATUS_OK;
         res_found_ff  <= '0;
      end else begin
         if (cmd.set_status) res_status_ff <= cmd.status;
         if (cmd.set_found) res_found_ff <= idx_ff;
      end
   end

   // Output register; it holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= alidf_pkg::FOUND_W'(res_found_ff);
         rsp_count_ff  <= alidf_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;

   // The list never holds more than DEPTH entries.
   `ALIDF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   // An insert adds exactly one entry.
   `ALIDF_ASSERT_NEXT(a_count_inc, clock, reset, cmd.cnt_inc, count_ff == $past(count_ff) + CNT_W'(1))
   // Shift moves write inside the list or into the slot just past its end.
   `ALIDF_ASSERT_IMPL(a_move_in_list, clock, reset, cmd.wr_move, CMP_W'(wr_addr) <= count_x)
   // A new result is loaded only when the previous one is gone or leaving.
   `ALIDF_ASSERT_IMPL(a_out_free, clock, reset, cmd.out_load, out_free)

endmodule

// ===== rtl/array_list_insert_delete_find.sv =====
// Top level of the array list block: controller plus datapath.
// Depends on alidf_pkg, alidf_ctrl and alidf_dpath.
//
// Usage: an ordered list of up to DEPTH elements, packed from position 1.
// Requests arrive on req_* (opcode, value, position) and are taken when
// req_valid is high and req_stall is low. Opcode find returns the lowest
// 0-based index holding the value, insert puts the value at a 1-based
// position and shifts later entries up, delete removes the entry at a
// 1-based position and shifts later entries down. Each request yields one
// response on rsp_* with status, found index and the count afterwards.
// One request is worked on at a time; the element memory has one registered
// read port and one write port, so each element examined (find) or moved
// (insert, delete) takes a read step and then a move step, and an insert
// ends with a write step for the new value. A new request is taken from the
// cycle the response appears, even while the receiver stalls it; a stalled
// response holds in its output register. Reset empties the list at once.
`timescale 1ns / 1ps

module array_list_insert_delete_find #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [alidf_pkg::OPC_W-1:0]     req_opcode,
   input  logic [alidf_pkg::VALUE_W-1:0]   req_value,
   input  logic [alidf_pkg::POS_W-1:0]     req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [alidf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [alidf_pkg::FOUND_W-1:0]   rsp_found_index,
   output logic [alidf_pkg::COUNT_W-1:0]   rsp_count
);

   alidf_pkg::cmd_type  cmd;
   alidf_pkg::stat_type st;

   // Sequencer for each request.
   alidf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Storage, compare and result registers.
   alidf_dpath #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_position    (req_position),
      .cmd             (cmd),
      .st              (st),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

endmodule

// ===== tb/sv/tb_array_list_insert_delete_find.sv =====
// Self-checking testbench for the array list block: random find, insert and delete traffic.
// A scoreboard class predicts each response; it depends on alidf_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_array_list_insert_delete_find;

   localparam int LIST_DEPTH = 64;
   localparam int ELEM_BITS = 32;
   localparam int RANDOM_ITEMS = 1930;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 160;
   localparam int IDLE_LIMIT = 3000;
   localparam int MAX_REPORTS = 10;

   // The fourth opcode does nothing in the block.
   localparam logic [alidf_pkg::OPC_W-1:0] OP_NOP = 2'd3;

   typedef struct {
      alidf_pkg::status_type status;
      logic [alidf_pkg::FOUND_W-1:0] found;
      logic [alidf_pkg::COUNT_W-1:0] count;
   } list_result_type;

   // Shadow copy of the list plus the queue of responses still to come.
   class list_tracker_type;
      logic [alidf_pkg::VALUE_W-1:0] cells [LIST_DEPTH];
      int unsigned fill;
      list_result_type pending_results [$];
      int unsigned mismatches;
      int unsigned responses;
      int unsigned op_seen [4];
      int unsigned status_seen [4];
      int unsigned peak;

      function new();
         fill = 0;
         mismatches = 0;
         responses = 0;
         peak = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Applies one accepted request to the shadow list and queues its response.
      function void note_request(logic [alidf_pkg::OPC_W-1:0] op,
                                 logic [alidf_pkg::VALUE_W-1:0] val,
                                 logic [alidf_pkg::POS_W-1:0] pos);
         list_result_type res;
         int p;
         bit hit;
         p = int'(pos);
         hit = 1'b0;
         res.status = alidf_pkg::STATUS_OK;
         res.found = '0;
         case (op)
            alidf_pkg::OP_FIND: begin
               for (int i = 0; i < int'(fill); i++) begin
                  if (!hit && cells[i] == val[ELEM_BITS-1:0]) begin
                     hit = 1'b1;
                     res.found = i[alidf_pkg::FOUND_W-1:0];
                  end
               end
               if (!hit) res.status = alidf_pkg::STATUS_NOT_FOUND;
            end
            alidf_pkg::OP_INSERT: begin
               // The full check wins over a bad position.
               if (fill >= LIST_DEPTH) begin
                  res.status = alidf_pkg::STATUS_FULL;
               end else if (p < 1 || p > int'(fill) + 1) begin
                  res.status = alidf_pkg::STATUS_BAD_POS;
               end else begin
                  for (int j = int'(fill); j >= p; j--) cells[j] = cells[j-1];
                  cells[p-1] = val;
                  fill++;
               end
            end
            alidf_pkg::OP_DELETE: begin
               if (p < 1 || p > int'(fill)) begin
                  res.status = alidf_pkg::STATUS_BAD_POS;
               end else begin
                  for (int j = p; j < int'(fill); j++) cells[j-1] = cells[j];
                  fill--;
               end
            end
            default: ;
         endcase
         res.count = fill[alidf_pkg::COUNT_W-1:0];
         if (fill > peak) peak = fill;
         op_seen[op]++;
         status_seen[res.status]++;
         pending_results.push_back(res);
      endfunction

      // Compares one accepted response with the oldest queued one.
      function void check_response(logic [alidf_pkg::STATUS_W-1:0] st,
                                   logic [alidf_pkg::FOUND_W-1:0] fi,
                                   logic [alidf_pkg::COUNT_W-1:0] cnt);
         list_result_type exp_res;
         responses++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("MISMATCH: response %0d arrived with nothing pending", responses);
            return;
         end
         exp_res = pending_results.pop_front();
         if (st !== exp_res.status || fi !== exp_res.found || cnt !== exp_res.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("MISMATCH: response %0d expected status %0d found %0d count %0d, %s",
                        responses, exp_res.status, exp_res.found, exp_res.count,
                        $sformatf("got status %0d found %0d count %0d", st, fi, cnt));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [alidf_pkg::OPC_W-1:0] req_opcode;
   logic [alidf_pkg::VALUE_W-1:0] req_value;
   logic [alidf_pkg::POS_W-1:0] req_position;
   logic rsp_valid;
   logic rsp_stall;
   logic [alidf_pkg::STATUS_W-1:0] rsp_status;
   logic [alidf_pkg::FOUND_W-1:0] rsp_found_index;
   logic [alidf_pkg::COUNT_W-1:0] rsp_count;

   list_tracker_type book;
   int unsigned sent;

   array_list_insert_delete_find #(
      .DEPTH(LIST_DEPTH),
      .ELEM_WIDTH(ELEM_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Random gap before an item, none in one quiet stretch of every 512 items.
   function automatic int unsigned draw_gap(int unsigned n, int unsigned quiet_phase);
      if ((n / 128) % 4 == quiet_phase) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Mostly small values so that finds hit duplicates, plus extremes and full-width noise.
   function automatic logic [alidf_pkg::VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return $urandom_range(0, 7);
      if (roll < 60) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   // Offers one request after a random gap and holds it until the block takes it.
   task automatic send_request(input logic [alidf_pkg::OPC_W-1:0] op,
                               input logic [alidf_pkg::VALUE_W-1:0] val,
                               input logic [alidf_pkg::POS_W-1:0] pos);
      int unsigned gap;
      gap = draw_gap(sent, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(op, val, pos);
      sent++;
   endtask

   // Edge cases on a short list: empty list, bad positions, duplicates, extremes.
   task automatic run_directed();
      send_request(alidf_pkg::OP_FIND, 32'd5, 7'd0);
      send_request(alidf_pkg::OP_DELETE, 32'd0, 7'd1);
      send_request(alidf_pkg::OP_DELETE, 32'd0, 7'd0);
      send_request(alidf_pkg::OP_INSERT, 32'd9, 7'd0);
      send_request(alidf_pkg::OP_INSERT, 32'd9, 7'd2);
      send_request(alidf_pkg::OP_INSERT, 32'h0000_0000, 7'd1);
      send_request(alidf_pkg::OP_INSERT, 32'hFFFF_FFFF, 7'd2);
      send_request(alidf_pkg::OP_INSERT, 32'h0000_0000, 7'd1);
      send_request(alidf_pkg::OP_INSERT, 32'h8000_0000, 7'd2);
      send_request(alidf_pkg::OP_FIND, 32'h0000_0000, 7'd0);
      send_request(alidf_pkg::OP_FIND, 32'hFFFF_FFFF, 7'd0);
      send_request(alidf_pkg::OP_FIND, 32'h0001_2345, 7'd0);
      send_request(alidf_pkg::OP_INSERT, 32'd3, 7'd127);
      send_request(alidf_pkg::OP_INSERT, 32'd3, 7'd6);
      send_request(alidf_pkg::OP_DELETE, 32'd0, 7'd5);
      send_request(alidf_pkg::OP_DELETE, 32'hFFFF_FFFF, 7'd127);
      send_request(OP_NOP, 32'hFFFF_FFFF, 7'd127);
      send_request(alidf_pkg::OP_DELETE, 32'd0, 7'd4);
      send_request(alidf_pkg::OP_DELETE, 32'd0, 7'd1);
      send_request(alidf_pkg::OP_DELETE, 32'd0, 7'd2);
      send_request(alidf_pkg::OP_FIND, 32'h0000_0000, 7'd127);
      send_request(alidf_pkg::OP_INSERT, 32'h7FFF_FFFF, 7'd1);
   endtask

   // Alternates between growing the list to full and shrinking it to empty.
   task automatic run_random_traffic(input int unsigned items);
      logic [alidf_pkg::OPC_W-1:0] op;
      logic [alidf_pkg::VALUE_W-1:0] val;
      logic [alidf_pkg::POS_W-1:0] pos;
      int unsigned roll;
      int unsigned fill;
      int unsigned span;
      bit growing;
      growing = 1'b1;
      for (int unsigned k = 0; k < items; k++) begin
         fill = book.fill;
         if (growing && fill == LIST_DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
         else if (!growing && fill == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;

         roll = $urandom_range(0, 99);
         if (roll < 3) op = OP_NOP;
         else if (roll < 22) op = alidf_pkg::OP_FIND;
         else if ((roll < 85) == growing) op = alidf_pkg::OP_INSERT;
         else op = alidf_pkg::OP_DELETE;

         // Mostly legal positions with the ends favored; some anywhere in the field.
         span = (op == alidf_pkg::OP_INSERT) ? fill + 1 : fill;
         roll = $urandom_range(0, 99);
         if (roll < 12 || span == 0) pos = alidf_pkg::POS_W'($urandom_range(0, 127));
         else if (roll < 20) pos = alidf_pkg::POS_W'(1);
         else if (roll < 28) pos = alidf_pkg::POS_W'(span);
         else pos = alidf_pkg::POS_W'($urandom_range(1, span));

         if (op == alidf_pkg::OP_FIND && fill != 0 && $urandom_range(0, 99) < 55)
            val = book.cells[$urandom_range(0, fill - 1)];
         else
            val = pick_value();
         send_request(op, val, pos);
      end
   endtask

   // Takes responses after random stalls, with two long hold-offs to back up the block.
   task automatic run_receiver();
      int unsigned taken;
      int unsigned gap;
      taken = 0;
      forever begin
         if (taken == 400 || taken == 1300) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = draw_gap(taken, 2);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         book.check_response(rsp_status, rsp_found_index, rsp_count);
         taken++;
      end
   endtask

   // Ends the run when no request or response moves for too long.
   initial begin
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Main sequence: reset, directed cases, random traffic, drain and verdict.
   initial begin
      book = new();
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = alidf_pkg::OP_FIND;
      req_value = '0;
      req_position = '0;
      rsp_stall = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         run_receiver();
      join_none
      run_directed();
      run_random_traffic(RANDOM_ITEMS);
      req_valid <= 1'b0;
      while (book.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.pending_results.size() != 0) begin
         book.mismatches++;
         $display("MISMATCH: %0d responses never arrived", book.pending_results.size());
      end
      $display("Covered %0d requests: find %0d, insert %0d, delete %0d, no-op %0d; peak %0d.",
               sent, book.op_seen[alidf_pkg::OP_FIND], book.op_seen[alidf_pkg::OP_INSERT],
               book.op_seen[alidf_pkg::OP_DELETE], book.op_seen[OP_NOP], book.peak);
      $display("Outcomes: ok %0d, full %0d, bad position %0d, not found %0d; mismatches %0d.",
               book.status_seen[alidf_pkg::STATUS_OK], book.status_seen[alidf_pkg::STATUS_FULL],
               book.status_seen[alidf_pkg::STATUS_BAD_POS],
               book.status_seen[alidf_pkg::STATUS_NOT_FOUND], book.mismatches);
      if (book.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
